FILE: hw/rtl/tsfcrc_pkg.sv
// tsfcrc_pkg: constants, step codes and helper functions for the sentence framer
// used by telemetry_sentence_framer_crc16_top; no other dependencies
`timescale 1ns / 1ps

package tsfcrc_pkg;

    // crc-16/ccitt constants
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // framing characters
    localparam logic [7:0]  PREFIX_CHAR  = 8'h24;
    localparam logic [7:0]  STAR_CHAR    = 8'h2A;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

    // output step index within one item's beat run
    typedef logic [3:0] t_step;

    localparam t_step STEP_PREFIX_FIRST = 4'd0;
    localparam t_step STEP_PREFIX_LAST  = 4'd5;
    localparam t_step STEP_BODY         = 4'd6;
    localparam t_step STEP_STAR         = 4'd7;
    localparam t_step STEP_HEX3         = 4'd8;
    localparam t_step STEP_HEX2         = 4'd9;
    localparam t_step STEP_HEX1         = 4'd10;
    localparam t_step STEP_HEX0         = 4'd11;
    localparam t_step STEP_NEWLINE      = 4'd12;

    // fold one byte into the crc, msb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // upper-case hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10) begin
            ch = 8'h30 + {4'h0, n};
        end else begin
            ch = 8'h37 + {4'h0, n};
        end
        return ch;
    endfunction

endpackage

FILE: hw/rtl/telemetry_sentence_framer_crc16_top.sv
// telemetry_sentence_framer_crc16_top: frames telemetry sentences and appends a crc-16/ccitt
// depends on tsfcrc_pkg
`timescale 1ns / 1ps

// Usage
//   slave channel: one payload character per beat on i_s_tdata, i_s_tlast marks
//   the last character of the sentence body.
//   master channel: one output character per beat on o_m_tdata. o_m_tlast marks
//   the final beat caused by one input beat, o_m_tuser marks the closing newline.
//   Before the first body character six '$' are sent; after the last one comes
//   '*', the crc as four upper-case hex digits and a newline.
// Path: the first output beat of an item goes from the item register, filled by the
//   accepting edge, to the output register.
// Throughput: one output beat per cycle while i_m_tready stays high, set by the single
//   output register. An inner body character gives one beat; an opening one is
//   preceded by the six '$', a closing one followed by '*', the four hex digits and
//   the newline. The next input beat is taken in the cycle the current item's final
//   beat enters the output register.
// Reset: clears the crc to 0xFFFF, returns to "prefix not yet sent" and drops
//   both valid flags.
// Stall: when i_m_tready is low the output beat holds, the sequencer stops and
//   o_s_tready falls once the item register is full.

module telemetry_sentence_framer_crc16_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] payload_byte
    input  logic       i_s_tlast,   // payload_last
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // run_end
    output logic       o_m_tuser    // [0] sentence_end
);

    // sentence state
    logic [15:0] r_crc, n_crc;
    logic        r_inside, n_inside;

    // item register
    logic                 r_a_valid, n_a_valid;
    logic [7:0]           r_a_byte;
    logic                 r_a_last;
    logic [15:0]          r_a_crc;
    tsfcrc_pkg::t_step    r_a_idx, n_a_idx;

    // output register
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_byte,  n_o_byte;
    logic       r_o_tlast, n_o_tlast;
    logic       r_o_tuser, n_o_tuser;

    logic              adv;
    logic              a_final;
    logic              accept;
    logic              in_open;
    logic [15:0]       fold_base;
    logic [15:0]       folded;
    tsfcrc_pkg::t_step end_idx;
    logic [7:0]        beat_byte;

    // handshake and sequencing control
    assign adv     = !r_o_valid || i_m_tready;
    assign end_idx = r_a_last ? tsfcrc_pkg::STEP_NEWLINE : tsfcrc_pkg::STEP_BODY;
    assign a_final = (r_a_idx == end_idx);
    assign o_s_tready = !r_a_valid || (adv && a_final);
    assign accept  = i_s_tvalid && o_s_tready;

    // crc update for the incoming byte
    assign in_open   = !r_inside;
    assign fold_base = in_open ? tsfcrc_pkg::CRC_INIT : r_crc;
    assign folded    = tsfcrc_pkg::crc_fold(fold_base, i_s_tdata);

    always_comb begin
        n_crc    = r_crc;
        n_inside = r_inside;
        if (accept) begin
            n_crc    = i_s_tlast ? tsfcrc_pkg::CRC_INIT : folded;
            n_inside = !i_s_tlast;
        end
    end

    // character for the current step
    always_comb begin
        case (r_a_idx)
            tsfcrc_pkg::STEP_BODY:    beat_byte = r_a_byte;
            tsfcrc_pkg::STEP_STAR:    beat_byte = tsfcrc_pkg::STAR_CHAR;
            tsfcrc_pkg::STEP_HEX3:    beat_byte = tsfcrc_pkg::hex_char(r_a_crc[15:12]);
            tsfcrc_pkg::STEP_HEX2:    beat_byte = tsfcrc_pkg::hex_char(r_a_crc[11:8]);
            tsfcrc_pkg::STEP_HEX1:    beat_byte = tsfcrc_pkg::hex_char(r_a_crc[7:4]);
            tsfcrc_pkg::STEP_HEX0:    beat_byte = tsfcrc_pkg::hex_char(r_a_crc[3:0]);
            tsfcrc_pkg::STEP_NEWLINE: beat_byte = tsfcrc_pkg::NEWLINE_CHAR;
            default:                  beat_byte = tsfcrc_pkg::PREFIX_CHAR;
        endcase
    end

    // item register next state
    always_comb begin
        n_a_valid = r_a_valid;
        n_a_idx   = r_a_idx;
        if (r_a_valid && adv) begin
            if (a_final) begin
                n_a_valid = 1'b0;
            end else begin
                n_a_idx = r_a_idx + 4'd1;
            end
        end
        if (accept) begin
            n_a_valid = 1'b1;
            n_a_idx   = in_open ? tsfcrc_pkg::STEP_PREFIX_FIRST : tsfcrc_pkg::STEP_BODY;
        end
    end

    // output register next state
    always_comb begin
        n_o_valid = r_o_valid;
        n_o_byte  = r_o_byte;
        n_o_tlast = r_o_tlast;
        n_o_tuser = r_o_tuser;
        if (adv) begin
            n_o_valid = r_a_valid;
            n_o_byte  = beat_byte;
            n_o_tlast = a_final;
            n_o_tuser = (r_a_idx == tsfcrc_pkg::STEP_NEWLINE);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= tsfcrc_pkg::CRC_INIT;
            r_inside  <= 1'b0;
            r_a_valid <= 1'b0;
            r_a_idx   <= tsfcrc_pkg::STEP_PREFIX_FIRST;
            r_o_valid <= 1'b0;
        end else begin
            r_crc     <= n_crc;
            r_inside  <= n_inside;
            r_a_valid <= n_a_valid;
            r_a_idx   <= n_a_idx;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_byte <= i_s_tdata;
            r_a_last <= i_s_tlast;
            r_a_crc  <= folded;
        end
        r_o_byte  <= n_o_byte;
        r_o_tlast <= n_o_tlast;
        r_o_tuser <= n_o_tuser;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_byte;
    assign o_m_tlast  = r_o_tlast;
    assign o_m_tuser  = r_o_tuser;

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for telemetry_sentence_framer_crc16_top, predicts the framed
// character stream with its own crc-16/ccitt and compares every output beat in order
// depends on tsfcrc_pkg and hw/rtl/telemetry_sentence_framer_crc16_top.sv
`timescale 1ns / 1ps

module testbench;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 30;
    localparam int TARGET_ITEMS   = 320;

    // one framed output character
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       sentence_end;
    } t_framed_char;

    // predicts the framed stream and checks each output beat against it
    class sentence_checker;
        logic [15:0]  crc;
        bit           in_body;
        t_framed_char expected_chars[$];
        int           errors;
        int           beats_in;
        int           beats_out;
        int           sentences;

        function new();
            crc       = tsfcrc_pkg::CRC_INIT;
            in_body   = 0;
            errors    = 0;
            beats_in  = 0;
            beats_out = 0;
            sentences = 0;
        endfunction

        // crc update one input bit at a time, msb first
        function logic [15:0] crc_serial_fold(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 7; i >= 0; i--) begin
                fb = r[15] ^ b[i];
                r  = {r[14:0], 1'b0} ^ (fb ? tsfcrc_pkg::CRC_POLY : 16'h0000);
            end
            return r;
        endfunction

        function logic [7:0] nibble_ascii(input logic [3:0] n);
            logic [7:0] a;
            if (n > 4'd9) begin
                a = 8'h41 + {4'h0, n} - 8'd10;
            end else begin
                a = 8'h30 + {4'h0, n};
            end
            return a;
        endfunction

        function void push_char(input logic [7:0] ch, input logic nl);
            t_framed_char f;
            f.ch           = ch;
            f.run_end      = 1'b0;
            f.sentence_end = nl;
            expected_chars.push_back(f);
        endfunction

        // accepted payload beat: queue every character it causes
        function void note_payload(input logic [7:0] b, input logic last);
            t_framed_char f;
            beats_in++;
            if (!in_body) begin
                for (int k = 0; k < 6; k++) push_char(tsfcrc_pkg::PREFIX_CHAR, 1'b0);
                crc     = tsfcrc_pkg::CRC_INIT;
                in_body = 1;
            end
            push_char(b, 1'b0);
            crc = crc_serial_fold(crc, b);
            if (last) begin
                push_char(tsfcrc_pkg::STAR_CHAR, 1'b0);
                push_char(nibble_ascii(crc[15:12]), 1'b0);
                push_char(nibble_ascii(crc[11:8]), 1'b0);
                push_char(nibble_ascii(crc[7:4]), 1'b0);
                push_char(nibble_ascii(crc[3:0]), 1'b0);
                push_char(tsfcrc_pkg::NEWLINE_CHAR, 1'b1);
                crc     = tsfcrc_pkg::CRC_INIT;
                in_body = 0;
                sentences++;
            end
            // the last character of this beat's run carries run_end
            f         = expected_chars.pop_back();
            f.run_end = 1'b1;
            expected_chars.push_back(f);
        endfunction

        // accepted output beat: compare with the oldest expected character
        function void check_char(input logic [7:0] ch, input logic re, input logic se);
            t_framed_char f;
            beats_out++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected output beat data=%h tlast=%b tuser=%b",
                         $time, ch, re, se);
                errors++;
                return;
            end
            f = expected_chars.pop_front();
            if (ch !== f.ch) begin
                $display("%0t: data mismatch expected=%h actual=%h", $time, f.ch, ch);
                errors++;
            end
            if (re !== f.run_end) begin
                $display("%0t: tlast mismatch expected=%b actual=%b", $time, f.run_end, re);
                errors++;
            end
            if (se !== f.sentence_end) begin
                $display("%0t: tuser mismatch expected=%b actual=%b",
                         $time, f.sentence_end, se);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] payload_byte
    logic       i_s_tlast;   // payload_last
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic       o_m_tlast;   // run_end
    logic       o_m_tuser;   // [0] sentence_end

    sentence_checker checker_h = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_start = 0;
    int hold_left  = 0;
    int cycle_cnt  = 0;
    int items_sent = 0;

    telemetry_sentence_framer_crc16_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_cnt, checker_h.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            checker_h.check_char(o_m_tdata, o_m_tlast, o_m_tuser);
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                i_m_tready <= 1'b0;
            end else if (hold_start) begin
                hold_start = 0;
                hold_left  = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one payload beat, idle first at random, return once accepted
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        checker_h.note_payload(b, last);
        items_sent++;
    endtask

    // random sentence body, mostly legal characters with an occasional zero byte
    task automatic send_sentence(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
                b = 8'h00;
            end else begin
                b = 8'($urandom_range(255, 1));
            end
            send_beat(b, i == len - 1);
        end
    endtask

    // stop offering and wait until every expected character has come out
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        int  phase;
        int  len;
        bit  held;
        bit  paused;
        held       = 0;
        paused     = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tlast  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-byte sentences at the extremes, zero byte
        send_beat(8'hFF, 1'b1);
        send_beat(8'h01, 1'b1);
        send_beat(8'h00, 1'b1);
        // multi-byte sentence with single-bit and alternating patterns
        send_beat(8'h80, 1'b0);
        send_beat(8'h7F, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h41, 1'b1);
        // body bytes that look like framing characters
        send_beat(8'h24, 1'b0);
        send_beat(8'h2A, 1'b0);
        send_beat(8'h0A, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        // a short sentence under both-sided idling
        idle_pct  = 59;
        stall_pct = 59;
        send_beat(8'h30, 1'b0);
        send_beat(8'h39, 1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        drain_results();

        // random sentences, rotating through the idling phases
        while (items_sent < TARGET_ITEMS) begin
            phase = (items_sent / 40) % 4;
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 59;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 59;
                end
                default: begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            if (!held && items_sent >= 120) begin
                // receiver holds off while the sender keeps pushing
                held       = 1;
                idle_pct   = 0;
                hold_start = 1;
                send_sentence(24);
            end else if (!paused && items_sent >= 200) begin
                // sender waits for the output to empty before going on
                paused = 1;
                drain_results();
                send_sentence(3);
            end else begin
                if ($urandom_range(9) == 0) begin
                    len = $urandom_range(40, 12);
                end else begin
                    len = $urandom_range(10, 1);
                end
                send_sentence(len);
            end
        end
        i_s_tvalid <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d sentences: %0d payload beats in, %0d characters out checked",
                 checker_h.sentences, checker_h.beats_in, checker_h.beats_out);
        $display("single-byte, zero-byte, long-body, stall and hold-off cases included");
        if (checker_h.errors == 0 && checker_h.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
